/* src/typed_constant_intern_table_defines.svh */
// ----------------------------------------------------------------------------
// typed constant intern table assertion macros
// shared concurrent check forms used by the table rtl
// ----------------------------------------------------------------------------
`ifndef TYPED_CONSTANT_INTERN_TABLE_DEFINES_SVH
`define TYPED_CONSTANT_INTERN_TABLE_DEFINES_SVH

// same-cycle implication
`define TCIT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCIT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tcit_pkg.sv */
// ----------------------------------------------------------------------------
// tcit_pkg
// shared sizes, kind codes and entry type of the typed constant intern table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcit_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MODE_W  = 3;
    localparam int VALUE_W = 64;
    localparam int INDEX_W = 8;
    localparam int KEY_W   = 32;
    localparam int ENTRY_W = MODE_W + VALUE_W;

    localparam logic [MODE_W-1:0] KIND_FLOAT = 3'd1;

    localparam logic [VALUE_W-1:0] ABS_MASK     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] EXP_ALL_ONES = 64'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic [MODE_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

/* src/tcit_ram.sv */
// ----------------------------------------------------------------------------
// tcit_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/tcit_match.sv */
// ----------------------------------------------------------------------------
// tcit_match
// shared entry compare unit: same kind and equal value, floats by ieee rules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcit_match (
    input  tcit_pkg::entry_t probe,
    input  tcit_pkg::entry_t stored,
    output logic             hit
);

    logic [tcit_pkg::VALUE_W-1:0] probe_abs;
    logic [tcit_pkg::VALUE_W-1:0] stored_abs;
    logic                         any_nan;
    logic                         both_zero;
    logic                         same_kind;
    logic                         same_bits;

    always_comb begin
        probe_abs  = probe.value & tcit_pkg::ABS_MASK;
        stored_abs = stored.value & tcit_pkg::ABS_MASK;
        any_nan    = (probe_abs > tcit_pkg::EXP_ALL_ONES) ||
                     (stored_abs > tcit_pkg::EXP_ALL_ONES);
        both_zero  = (probe_abs == '0) && (stored_abs == '0);
        same_kind  = (probe.kind == stored.kind);
        same_bits  = (probe.value == stored.value);
        if (!same_kind) begin
            hit = 1'b0;
        end else if (probe.kind == tcit_pkg::KIND_FLOAT) begin
            hit = !any_nan && (both_zero || same_bits);
        end else begin
            hit = same_bits;
        end
    end

endmodule

/* src/typed_constant_intern_table.sv */
// a hit ends the scan at the first equal entry; a miss reads all N stored entries
// (none on an empty table), N the stored entry count, then appends or flags full
// output stalls hold the answer back; one request is scanned at a time
// the scan reads one entry a cycle through the table ram read port into one compare unit
// a new request is taken while the previous result waits on the output register
// reset clears the entry count and handshake state; table contents stay as they are
// ----------------------------------------------------------------------------
// typed_constant_intern_table
// interns kind/value constants, returning the first equal entry, flagging full or appending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "typed_constant_intern_table_defines.svh"

module typed_constant_intern_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tcit_pkg::VALUE_W-1:0]  s_tdata,   // [63:0] value
    input  logic [tcit_pkg::MODE_W-1:0]   s_tuser,   // [2:0] mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tcit_pkg::INDEX_W-1:0]  m_tdata,   // [7:0] index
    output logic                          m_tuser    // [0] full_res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    tcit_pkg::entry_t              probe_reg, probe_next;
    logic [tcit_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [tcit_pkg::CNT_W-1:0]    issue_reg, issue_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    logic [tcit_pkg::IDX_W-1:0]    cmp_ptr_reg, cmp_ptr_next;
    logic [tcit_pkg::INDEX_W-1:0]  res_index_reg, res_index_next;
    logic                          res_full_reg, res_full_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [tcit_pkg::INDEX_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    logic                          ram_wr_en;
    logic                          ram_rd_en;
    tcit_pkg::entry_t              ram_rd_data;
    tcit_pkg::entry_t              in_entry;
    logic                          match_hit;
    logic                          hit;
    logic                          scan_end;
    logic                          table_full;

    tcit_ram #(
        .WIDTH (tcit_pkg::ENTRY_W),
        .DEPTH (tcit_pkg::TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[tcit_pkg::IDX_W-1:0]),
        .wr_data (probe_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_reg[tcit_pkg::IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    tcit_match u_match (
        .probe  (probe_reg),
        .stored (ram_rd_data),
        .hit    (match_hit)
    );

    always_comb begin
        in_entry.kind = s_tuser;
        if (s_tuser == tcit_pkg::KIND_FLOAT) begin
            in_entry.value = s_tdata;
        end else begin
            in_entry.value = {{(tcit_pkg::VALUE_W - tcit_pkg::KEY_W){1'b0}},
                              s_tdata[tcit_pkg::KEY_W-1:0]};
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign hit        = cmp_valid_reg && match_hit;
    assign scan_end   = !cmp_valid_reg && (issue_reg == count_reg);
    assign table_full = (count_reg == tcit_pkg::CNT_W'(tcit_pkg::TABLE_DEPTH));
    assign ram_rd_en  = (state_reg == ST_SCAN) && !hit && (issue_reg != count_reg);
    assign ram_wr_en  = (state_reg == ST_SCAN) && !hit && scan_end && !table_full;

    always_comb begin
        state_next     = state_reg;
        probe_next     = probe_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_ptr_next   = cmp_ptr_reg;
        res_index_next = res_index_reg;
        res_full_next  = res_full_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    probe_next = in_entry;
                    issue_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    res_index_next = tcit_pkg::INDEX_W'(cmp_ptr_reg);
                    res_full_next  = 1'b0;
                    state_next     = ST_OUT;
                end else if (scan_end) begin
                    if (table_full) begin
                        res_index_next = '0;
                        res_full_next  = 1'b1;
                    end else begin
                        res_index_next = tcit_pkg::INDEX_W'(count_reg);
                        res_full_next  = 1'b0;
                        count_next     = count_reg + 1'b1;
                    end
                    state_next = ST_OUT;
                end else begin
                    if (ram_rd_en) begin
                        issue_next = issue_reg + 1'b1;
                    end
                    cmp_valid_next = ram_rd_en;
                    cmp_ptr_next   = issue_reg[tcit_pkg::IDX_W-1:0];
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_index_reg;
                    m_tuser_next  = res_full_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        probe_reg     <= probe_next;
        cmp_ptr_reg   <= cmp_ptr_next;
        res_index_reg <= res_index_next;
        res_full_reg  <= res_full_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `TCIT_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= tcit_pkg::CNT_W'(tcit_pkg::TABLE_DEPTH), "entry count beyond depth")
    `TCIT_ASSERT_IMPL(a_full_only_when_full, aclk, aresetn, m_tvalid && m_tuser,
        table_full, "full result while table has room")
    `TCIT_ASSERT_NEXT(a_append_grows, aclk, aresetn, ram_wr_en,
        count_reg == $past(count_reg) + 1'b1, "append without count step")
    `TCIT_ASSERT_IMPL(a_compare_in_scan, aclk, aresetn, cmp_valid_reg,
        state_reg == ST_SCAN, "compare data outside scan")

endmodule

/* tb/typed_constant_intern_table_checker.sv */
// ----------------------------------------------------------------------------
// typed_constant_intern_table_checker
// watches both stream channels, keeps a shadow constant table that predicts
// the index and full flag of every request, and compares each answer in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module typed_constant_intern_table_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [tcit_pkg::VALUE_W-1:0]  s_tdata,   // [63:0] value
    input  logic [tcit_pkg::MODE_W-1:0]   s_tuser,   // [2:0] mode
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [tcit_pkg::INDEX_W-1:0]  m_tdata,   // [7:0] index
    input  logic                          m_tuser,   // [0] full_res
    output int unsigned                   mismatches,
    output int unsigned                   answers_waiting,
    output int unsigned                   reused_hits,
    output int unsigned                   new_entries,
    output int unsigned                   full_refusals
);

    typedef struct packed {
        logic [tcit_pkg::INDEX_W-1:0] index;
        logic                         full;
    } intern_answer_t;

    logic [tcit_pkg::MODE_W-1:0]  shadow_kind [tcit_pkg::TABLE_DEPTH];
    logic [tcit_pkg::VALUE_W-1:0] shadow_bits [tcit_pkg::TABLE_DEPTH];
    int unsigned                  shadow_used = 0;
    intern_answer_t               answers_due [$];
    int unsigned                  err_count = 0;
    int unsigned                  hit_count = 0;
    int unsigned                  add_count = 0;
    int unsigned                  full_count = 0;

    function automatic bit is_nan_double(input logic [tcit_pkg::VALUE_W-1:0] v);
        return (v & tcit_pkg::ABS_MASK) > tcit_pkg::EXP_ALL_ONES;
    endfunction

    // ieee equality: signed zeros meet, nan never does
    function automatic bit same_double(input logic [tcit_pkg::VALUE_W-1:0] a,
                                       input logic [tcit_pkg::VALUE_W-1:0] b);
        if (is_nan_double(a) || is_nan_double(b))
            return 1'b0;
        if ((a & tcit_pkg::ABS_MASK) == '0 && (b & tcit_pkg::ABS_MASK) == '0)
            return 1'b1;
        return a == b;
    endfunction

    function automatic intern_answer_t intern_constant(
        input  logic [tcit_pkg::MODE_W-1:0]  kind,
        input  logic [tcit_pkg::VALUE_W-1:0] raw,
        output bit                           appended
    );
        intern_answer_t               ans;
        logic [tcit_pkg::VALUE_W-1:0] key;
        bit                           hit;
        appended = 1'b0;
        key = (kind == tcit_pkg::KIND_FLOAT) ? raw : {32'd0, raw[31:0]};
        for (int i = 0; i < shadow_used; i++) begin
            if (shadow_kind[i] != kind)
                continue;
            hit = (kind == tcit_pkg::KIND_FLOAT) ? same_double(shadow_bits[i], key)
                                                 : (shadow_bits[i] == key);
            if (hit) begin
                ans.index = i[tcit_pkg::INDEX_W-1:0];
                ans.full  = 1'b0;
                return ans;
            end
        end
        if (shadow_used >= tcit_pkg::TABLE_DEPTH) begin
            ans.index = '0;
            ans.full  = 1'b1;
            return ans;
        end
        shadow_kind[shadow_used] = kind;
        shadow_bits[shadow_used] = key;
        ans.index = shadow_used[tcit_pkg::INDEX_W-1:0];
        ans.full  = 1'b0;
        shadow_used++;
        appended = 1'b1;
        return ans;
    endfunction

    always @(posedge aclk) begin
        intern_answer_t want;
        bit             appended;
        if (!aresetn) begin
            shadow_used = 0;
            answers_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                want = intern_constant(s_tuser, s_tdata, appended);
                answers_due.push_back(want);
                if (want.full)
                    full_count++;
                else if (appended)
                    add_count++;
                else
                    hit_count++;
            end
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected answer index %0d full %0b", $time,
                             m_tdata, m_tuser);
                    err_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (m_tdata !== want.index) begin
                        $display("%0t: index mismatch expected %0d actual %0d", $time,
                                 want.index, m_tdata);
                        err_count++;
                    end
                    if (m_tuser !== want.full) begin
                        $display("%0t: full flag mismatch expected %0b actual %0b", $time,
                                 want.full, m_tuser);
                        err_count++;
                    end
                end
            end
        end
        mismatches      <= err_count;
        answers_waiting <= answers_due.size();
        reused_hits     <= hit_count;
        new_entries     <= add_count;
        full_refusals   <= full_count;
    end

endmodule

/* tb/typed_constant_intern_table_tb.sv */
// ----------------------------------------------------------------------------
// typed_constant_intern_table_tb
// drives typed constants into the intern table with random gaps and output
// stalls: directed float zero, nan, infinity and kind separation cases, then
// random mixes of repeated and fresh constants that fill the table past full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module typed_constant_intern_table_tb;

    typedef enum logic [2:0] {
        K_INT    = 3'd0,
        K_FLOAT  = 3'd1,
        K_STRING = 3'd2,
        K_IDENT  = 3'd3,
        K_LOGIC  = 3'd4,
        K_RSVD5  = 3'd5,
        K_RSVD6  = 3'd6,
        K_RSVD7  = 3'd7
    } const_kind_t;

    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int          RANDOM_REQUESTS = 725;
    localparam int          PAUSE_AT        = 300;
    localparam int          DRAIN_CYCLES    = tcit_pkg::TABLE_DEPTH + 8;

    localparam logic [63:0] DBL_POS_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] DBL_POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DBL_NEG_INF  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] DBL_QNAN     = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] DBL_NEG_SNAN = 64'hFFF0_0000_0000_0001;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    int unsigned mismatches;
    int unsigned answers_waiting;
    int unsigned reused_hits;
    int unsigned new_entries;
    int unsigned full_refusals;
    int unsigned cycles = 0;
    int unsigned sent = 0;

    logic [2:0]  sent_kind [$];
    logic [63:0] sent_bits [$];

    typed_constant_intern_table uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    typed_constant_intern_table_checker intern_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .answers_waiting (answers_waiting),
        .reused_hits     (reused_hits),
        .new_entries     (new_entries),
        .full_refusals   (full_refusals)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output stalls, none while requests 200 to 329 are taken
    always @(posedge aclk) begin
        int unsigned taken;
        taken = reused_hits + new_entries + full_refusals;
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= (taken >= 200 && taken < 330) || ($urandom_range(99) >= 32);
    end

    task automatic send_constant(input logic [2:0] kind, input logic [63:0] raw);
        if (!(sent >= 200 && sent < 330) && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 32);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= raw;
        do @(posedge aclk); while (!s_tready);
        sent++;
        sent_kind.push_back(kind);
        sent_bits.push_back(raw);
    endtask

    initial begin
        logic [2:0]  kind;
        logic [63:0] bits;
        int unsigned pick;
        int unsigned slot;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // high half ignored for 32-bit kinds, kinds kept apart
        send_constant(K_INT,    64'h0000_0000_0000_0000);
        send_constant(K_INT,    64'hFFFF_FFFF_0000_0000);
        send_constant(K_INT,    64'h0000_0000_FFFF_FFFF);
        send_constant(K_INT,    64'h0000_0000_7FFF_FFFF);
        send_constant(K_LOGIC,  64'h0000_0000_0000_0000);
        send_constant(K_LOGIC,  64'h0000_0000_0000_0001);
        // signed zeros, nan, infinities
        send_constant(K_FLOAT,  DBL_POS_ZERO);
        send_constant(K_FLOAT,  DBL_NEG_ZERO);
        send_constant(K_FLOAT,  DBL_QNAN);
        send_constant(K_FLOAT,  DBL_QNAN);
        send_constant(K_FLOAT,  DBL_NEG_SNAN);
        send_constant(K_FLOAT,  64'hFFFF_FFFF_FFFF_FFFF);
        send_constant(K_FLOAT,  DBL_POS_INF);
        send_constant(K_FLOAT,  DBL_POS_INF);
        send_constant(K_FLOAT,  DBL_NEG_INF);
        send_constant(K_FLOAT,  64'h0000_0000_0000_0001);
        send_constant(K_FLOAT,  64'h8000_0000_0000_0001);
        send_constant(K_STRING, 64'h0000_0000_8000_0000);
        send_constant(K_IDENT,  64'h0000_0000_8000_0000);
        send_constant(K_IDENT,  64'hDEAD_BEEF_8000_0000);
        // undefined kinds each stand alone
        send_constant(K_RSVD5,  64'h0000_0000_1234_5678);
        send_constant(K_RSVD6,  64'h0000_0000_1234_5678);
        send_constant(K_RSVD7,  64'h0000_0000_1234_5678);
        send_constant(K_RSVD5,  64'hABCD_0000_1234_5678);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(99);
            if ($urandom_range(3) == 0)
                kind = 3'($urandom_range(7));
            else
                kind = 3'($urandom_range(4));
            bits = {$urandom, $urandom};
            if (pick < 45) begin
                slot = $urandom_range(sent_kind.size() - 1);
                kind = sent_kind[slot];
                bits = sent_bits[slot];
                if (kind != K_FLOAT)
                    bits[63:32] = $urandom;
                else if (bits[62:0] == '0)
                    bits[63] = 1'($urandom_range(1));
            end else if (kind == K_FLOAT && pick < 80) begin
                case ($urandom_range(3))
                    0: bits[62:0] = '0;
                    1: begin
                        bits[62:52] = '1;
                        bits[51:0]  = '0;
                    end
                    2: begin
                        bits[62:52] = '1;
                        bits[0]     = 1'b1;
                    end
                    default: bits[62:52] = '0;
                endcase
            end else if (pick < 60) begin
                bits[31:0] = $urandom_range(15);
            end
            if (n == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (answers_waiting != 0) @(posedge aclk);
            end
            send_constant(kind, bits);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (answers_waiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests: %0d matched earlier entries, %0d appended, %0d refused full",
                 sent, reused_hits, new_entries, full_refusals);
        $display("including signed zeros, nans, infinities, ignored high halves, undefined kinds");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/tcit_pkg.sv
src/tcit_ram.sv
src/tcit_match.sv
src/typed_constant_intern_table.sv
tb/typed_constant_intern_table_checker.sv
tb/typed_constant_intern_table_tb.sv
